[rtl/core/jts_pkg.sv]
// ----------------------------------------------------------------------------
// jts_pkg: shared types and constants of the json token scanner
// token kinds, character codes, keyword tables, result and queue entry types
// ----------------------------------------------------------------------------
package jts_pkg;

	// token kinds
	localparam logic [3:0] KIND_LBRACE   = 4'd0;
	localparam logic [3:0] KIND_RBRACE   = 4'd1;
	localparam logic [3:0] KIND_LBRACKET = 4'd2;
	localparam logic [3:0] KIND_RBRACKET = 4'd3;
	localparam logic [3:0] KIND_COLON    = 4'd4;
	localparam logic [3:0] KIND_COMMA    = 4'd5;
	localparam logic [3:0] KIND_STRING   = 4'd6;
	localparam logic [3:0] KIND_NUMBER   = 4'd7;
	localparam logic [3:0] KIND_TRUE     = 4'd8;
	localparam logic [3:0] KIND_FALSE    = 4'd9;
	localparam logic [3:0] KIND_NULL     = 4'd10;
	localparam logic [3:0] KIND_END      = 4'd11;
	localparam logic [3:0] KIND_ERROR    = 4'd12;

	// character codes
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_0        = 8'h30;
	localparam logic [7:0] CH_9        = 8'h39;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_E_UP     = 8'h45;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_E_LO     = 8'h65;
	localparam logic [7:0] CH_F        = 8'h66;
	localparam logic [7:0] CH_N        = 8'h6E;
	localparam logic [7:0] CH_T        = 8'h74;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	// keyword selects and tables
	localparam logic [1:0] KW_NULL  = 2'd0;
	localparam logic [1:0] KW_TRUE  = 2'd1;
	localparam logic [1:0] KW_FALSE = 2'd2;
	localparam int KW_COUNT = 3;
	localparam int KW_MAX_LEN = 5;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
		'{"n", "u", "l", "l", 8'h00},
		'{"t", "r", "u", "e", 8'h00},
		'{"f", "a", "l", "s", "e"}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd4, 3'd5};
	localparam logic [3:0] KW_KIND [KW_COUNT] = '{KIND_NULL, KIND_TRUE, KIND_FALSE};

	// results per byte and queue sizing
	localparam int MAX_RESULTS = 4;
	localparam int RES_IDX_W = $clog2(MAX_RESULTS);
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH = 4;

	// one result item
	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] ch;
		logic       valid;
		logic       last;
	} result_t;

	// all results caused by one byte, one queue entry
	typedef struct packed {
		logic [RES_CNT_W-1:0]         cnt;
		result_t [MAX_RESULTS-1:0]    res;
	} group_t;

endpackage

[rtl/core/jts_front.sv]
// ----------------------------------------------------------------------------
// jts_front: byte acceptance and token classification
// runs the scan state machine on each accepted byte and writes the results
// it causes, if any, into the queue as one entry
// ----------------------------------------------------------------------------
module jts_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      text_byte,
	input  logic            q_full,
	output logic            q_push,
	output jts_pkg::group_t q_wdata
);
	import jts_pkg::*;

	localparam int SCAN_PASSES = 4;

	typedef enum logic [10:0] {
		MODE_IDLE      = 11'b000_0000_0001,
		MODE_STR       = 11'b000_0000_0010,
		MODE_ESC       = 11'b000_0000_0100,
		MODE_KEY       = 11'b000_0000_1000,
		MODE_MINUS     = 11'b000_0001_0000,
		MODE_MINUS_DOT = 11'b000_0010_0000,
		MODE_INT       = 11'b000_0100_0000,
		MODE_FRAC      = 11'b000_1000_0000,
		MODE_EXP_MARK  = 11'b001_0000_0000,
		MODE_EXP_SIGN  = 11'b010_0000_0000,
		MODE_EXP_DIG   = 11'b100_0000_0000
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] kw_sel;
		logic [2:0] kw_idx;
		logic [7:0] held0;
		logic [7:0] held1;
		logic       halted;
	} scan_t;

	typedef struct packed {
		scan_t  s;
		group_t g;
		logic   done;
	} pass_t;

	// append one result, dropping any beyond the entry size
	function automatic group_t group_add(group_t g, logic [3:0] kind, logic [7:0] ch,
			logic valid, logic last);
		group_t r;
		r = g;
		if (g.cnt < RES_CNT_W'(MAX_RESULTS)) begin
			r.res[g.cnt[RES_IDX_W-1:0]] = '{kind: kind, ch: ch, valid: valid, last: last};
			r.cnt = g.cnt + 1'b1;
		end
		return r;
	endfunction

	// one scan of the byte in the current mode; done low asks for a rescan
	function automatic pass_t scan_pass(pass_t p, logic [7:0] b);
		pass_t      q;
		logic       dig;
		logic [1:0] sel;
		logic [2:0] kl;
		logic [7:0] kc;
		logic [2:0] nidx;
		q = p;
		q.done = 1'b1;
		dig = (b >= CH_0) && (b <= CH_9);
		sel = (p.s.kw_sel > KW_FALSE) ? KW_NULL : p.s.kw_sel;
		kl = KW_LEN[sel];
		kc = (p.s.kw_idx < 3'(KW_MAX_LEN)) ? KW_TEXT[sel][p.s.kw_idx] : CH_NUL;
		nidx = p.s.kw_idx + 3'd1;
		unique case (p.s.mode)
			MODE_STR: begin
				if (b == CH_NUL) begin
					q.g = group_add(q.g, KIND_STRING, CH_NUL, 1'b0, 1'b1);
					q.s.mode = MODE_IDLE;
					q.done = 1'b0;
				end else if (b == CH_QUOTE) begin
					q.g = group_add(q.g, KIND_STRING, CH_NUL, 1'b0, 1'b1);
					q.s.mode = MODE_IDLE;
				end else begin
					q.g = group_add(q.g, KIND_STRING, b, 1'b1, 1'b0);
					if (b == CH_BSLASH) q.s.mode = MODE_ESC;
				end
			end
			MODE_ESC: begin
				if (b == CH_NUL) begin
					q.g = group_add(q.g, KIND_STRING, CH_NUL, 1'b0, 1'b1);
					q.s.mode = MODE_IDLE;
					q.done = 1'b0;
				end else begin
					q.g = group_add(q.g, KIND_STRING, b, 1'b1, 1'b0);
					q.s.mode = MODE_STR;
				end
			end
			MODE_KEY: begin
				if ((p.s.kw_idx < kl) && (b == kc)) begin
					if (nidx >= kl) begin
						q.g = group_add(q.g, KW_KIND[sel], CH_NUL, 1'b0, 1'b1);
						q.s.mode = MODE_IDLE;
						q.s.kw_idx = 3'd0;
					end else begin
						q.s.kw_idx = nidx;
					end
				end else begin
					q.g = group_add(q.g, KIND_ERROR, CH_NUL, 1'b0, 1'b1);
					q.s.halted = 1'b1;
					q.s.mode = MODE_IDLE;
					q.s.kw_idx = 3'd0;
				end
			end
			MODE_MINUS: begin
				if (dig) begin
					q.g = group_add(q.g, KIND_NUMBER, CH_MINUS, 1'b1, 1'b0);
					q.g = group_add(q.g, KIND_NUMBER, b, 1'b1, 1'b0);
					q.s.mode = MODE_INT;
				end else if (b == CH_DOT) begin
					q.s.held1 = b;
					q.s.mode = MODE_MINUS_DOT;
				end else begin
					q.s.mode = MODE_IDLE;
					q.done = 1'b0;
				end
			end
			MODE_MINUS_DOT: begin
				if (dig) begin
					q.g = group_add(q.g, KIND_NUMBER, CH_MINUS, 1'b1, 1'b0);
					q.g = group_add(q.g, KIND_NUMBER, CH_DOT, 1'b1, 1'b0);
					q.g = group_add(q.g, KIND_NUMBER, b, 1'b1, 1'b0);
					q.s.mode = MODE_FRAC;
				end else begin
					q.s.mode = MODE_IDLE;
					q.done = 1'b0;
				end
			end
			MODE_INT, MODE_FRAC: begin
				if (dig) begin
					q.g = group_add(q.g, KIND_NUMBER, b, 1'b1, 1'b0);
				end else if ((b == CH_DOT) && (p.s.mode == MODE_INT)) begin
					q.g = group_add(q.g, KIND_NUMBER, b, 1'b1, 1'b0);
					q.s.mode = MODE_FRAC;
				end else if ((b == CH_E_LO) || (b == CH_E_UP)) begin
					q.s.held0 = b;
					q.s.mode = MODE_EXP_MARK;
				end else begin
					q.g = group_add(q.g, KIND_NUMBER, CH_NUL, 1'b0, 1'b1);
					q.s.mode = MODE_IDLE;
					q.done = 1'b0;
				end
			end
			MODE_EXP_MARK: begin
				if (dig) begin
					q.g = group_add(q.g, KIND_NUMBER, p.s.held0, 1'b1, 1'b0);
					q.g = group_add(q.g, KIND_NUMBER, b, 1'b1, 1'b0);
					q.s.mode = MODE_EXP_DIG;
				end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
					q.s.held1 = b;
					q.s.mode = MODE_EXP_SIGN;
				end else begin
					q.g = group_add(q.g, KIND_NUMBER, CH_NUL, 1'b0, 1'b1);
					q.s.mode = MODE_IDLE;
					q.done = 1'b0;
				end
			end
			MODE_EXP_SIGN: begin
				if (dig) begin
					q.g = group_add(q.g, KIND_NUMBER, p.s.held0, 1'b1, 1'b0);
					q.g = group_add(q.g, KIND_NUMBER, p.s.held1, 1'b1, 1'b0);
					q.g = group_add(q.g, KIND_NUMBER, b, 1'b1, 1'b0);
					q.s.mode = MODE_EXP_DIG;
				end else begin
					// held sign minus starts a new number on rescan
					q.g = group_add(q.g, KIND_NUMBER, CH_NUL, 1'b0, 1'b1);
					q.s.mode = MODE_IDLE;
					if (p.s.held1 == CH_MINUS) begin
						q.s.held0 = CH_MINUS;
						q.s.mode = MODE_MINUS;
					end
					q.done = 1'b0;
				end
			end
			MODE_EXP_DIG: begin
				if (dig) begin
					q.g = group_add(q.g, KIND_NUMBER, b, 1'b1, 1'b0);
				end else begin
					q.g = group_add(q.g, KIND_NUMBER, CH_NUL, 1'b0, 1'b1);
					q.s.mode = MODE_IDLE;
					q.done = 1'b0;
				end
			end
			default: begin
				// between tokens: classify the start byte
				q.s.mode = MODE_IDLE;
				priority if (b == CH_NUL) begin
					q.g = group_add(q.g, KIND_END, CH_NUL, 1'b0, 1'b1);
				end else if (b <= CH_SPACE) begin
					q.s.mode = MODE_IDLE;
				end else if (b == CH_LBRACE) begin
					q.g = group_add(q.g, KIND_LBRACE, CH_NUL, 1'b0, 1'b1);
				end else if (b == CH_RBRACE) begin
					q.g = group_add(q.g, KIND_RBRACE, CH_NUL, 1'b0, 1'b1);
				end else if (b == CH_LBRACKET) begin
					q.g = group_add(q.g, KIND_LBRACKET, CH_NUL, 1'b0, 1'b1);
				end else if (b == CH_RBRACKET) begin
					q.g = group_add(q.g, KIND_RBRACKET, CH_NUL, 1'b0, 1'b1);
				end else if (b == CH_COLON) begin
					q.g = group_add(q.g, KIND_COLON, CH_NUL, 1'b0, 1'b1);
				end else if (b == CH_COMMA) begin
					q.g = group_add(q.g, KIND_COMMA, CH_NUL, 1'b0, 1'b1);
				end else if (b == CH_QUOTE) begin
					q.s.mode = MODE_STR;
				end else if (b == CH_N) begin
					q.s.kw_sel = KW_NULL;
					q.s.kw_idx = 3'd1;
					q.s.mode = MODE_KEY;
				end else if (b == CH_T) begin
					q.s.kw_sel = KW_TRUE;
					q.s.kw_idx = 3'd1;
					q.s.mode = MODE_KEY;
				end else if (b == CH_F) begin
					q.s.kw_sel = KW_FALSE;
					q.s.kw_idx = 3'd1;
					q.s.mode = MODE_KEY;
				end else if (b == CH_MINUS) begin
					q.s.held0 = CH_MINUS;
					q.s.mode = MODE_MINUS;
				end else if (dig) begin
					q.g = group_add(q.g, KIND_NUMBER, b, 1'b1, 1'b0);
					q.s.mode = MODE_INT;
				end else begin
					q.s.mode = MODE_IDLE;
				end
			end
		endcase
		return q;
	endfunction

	scan_t state_q;
	pass_t scan;
	logic  accept;

	// up to four scans of the same byte, a rescan whenever a pass asks for one
	always_comb begin
		scan = '{s: state_q, g: '0, done: 1'b0};
		for (int i = 0; i < SCAN_PASSES; i++) begin
			if (!scan.done && !scan.s.halted) scan = scan_pass(scan, text_byte);
		end
	end

	// byte transfer and queue write
	assign full    = q_full;
	assign accept  = push && !q_full;
	assign q_push  = accept && (scan.g.cnt != '0);
	assign q_wdata = scan.g;

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_IDLE, kw_sel: KW_NULL, kw_idx: 3'd0,
				held0: CH_NUL, held1: CH_NUL, halted: 1'b0};
		end else if (accept) begin
			state_q <= scan.s;
		end
	end

endmodule

[rtl/core/jts_queue.sv]
// ----------------------------------------------------------------------------
// jts_queue: result group queue
// holds the result groups of up to DEPTH bytes between the scanner and the output side
// ----------------------------------------------------------------------------
module jts_queue #(
	parameter int DEPTH = jts_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jts_pkg::group_t wdata,
	input  logic            pop,
	output jts_pkg::group_t rdata,
	output logic            full,
	output logic            empty
);
	import jts_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	group_t            entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	// status and head entry
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/jts_back.sv]
// ----------------------------------------------------------------------------
// jts_back: result delivery
// takes one group from the queue and hands its results out one per transfer
// ----------------------------------------------------------------------------
module jts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  jts_pkg::group_t q_rdata,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [3:0]      token_kind,
	output logic [7:0]      char_value,
	output logic            char_valid,
	output logic            token_last
);
	import jts_pkg::*;

	group_t               cur_q;
	logic                 valid_q;
	logic [RES_IDX_W-1:0] idx_q;
	logic                 last_res;
	logic                 advance;
	result_t              head;

	// advance to the next group when none is held or its last result goes
	assign last_res = ({1'b0, idx_q} + 1'b1) == cur_q.cnt;
	assign advance  = !valid_q || (pop && last_res);
	assign q_pop    = advance && !q_empty;

	// result ports
	assign head       = cur_q.res[idx_q];
	assign empty      = !valid_q;
	assign token_kind = head.kind;
	assign char_value = head.ch;
	assign char_valid = head.valid;
	assign token_last = head.last;

	// current group payload
	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_rdata;
	end

	// group valid and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= !q_empty;
			idx_q   <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

[rtl/core/json_token_scanner.sv]
// ----------------------------------------------------------------------------
// json_token_scanner: byte-serial json lexer
// classifies json text one byte at a time and delivers punctuation, keyword,
// end and error tokens, and string and number tokens one character at a time
//
//   channel   direction  handshake          payload
//   text      in         push / full        text_byte
//   tokens    out        pop / empty        token_kind, char_value,
//                                           char_valid, token_last
//
// one byte is taken per cycle while the result queue has room; results leave
// at one per cycle while pop is held, so bytes causing two or three results
// throttle intake; a byte's results are written into the queue at the transfer
// edge and reach the output ports once the output group register has loaded
// them from the queue head
// the queue holds QUEUE_DEPTH byte groups; full rises only when it is full
// reset clears the scan state, the queue and the output side at once
// ----------------------------------------------------------------------------
module json_token_scanner #(
	parameter int QUEUE_DEPTH = jts_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] token_kind,
	output logic [7:0] char_value,
	output logic       char_valid,
	output logic       token_last
);
	import jts_pkg::*;

	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	group_t q_wdata;
	group_t q_rdata;

	// scanner front
	jts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text_byte (text_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	// group queue
	jts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// result delivery
	jts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.token_kind (token_kind),
		.char_value (char_value),
		.char_valid (char_valid),
		.token_last (token_last)
	);

	// front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue write while full");

	// back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	// only groups holding results are queued
	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_wdata.cnt != '0))
		else $error("empty group queued");

	// a result that is not the last of its token is a string or number character
	a_char_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !token_last) |->
			(char_valid && ((token_kind == KIND_STRING) || (token_kind == KIND_NUMBER))))
		else $error("non-final result is not a token character");

endmodule
